FILE: rtl/core/rafc_pkg.sv
// rafc_pkg: shared types, codes and constants for the region area fill classifier.
// Used by every module under rtl/core except rafc_ram. It depends on nothing.
package rafc_pkg;

  localparam int COORD_W = 10;
  localparam int AREA_W  = 21;
  localparam int PIX_W   = 8;
  localparam int LAB_W   = 8;
  localparam int RATIO_W = 24;
  localparam int WH_W    = 2 * COORD_W;
  localparam int PROD_W  = RATIO_W + WH_W;
  localparam int FRAC_W  = 16;

  localparam int DEF_MAX_LABELS = 256;
  localparam int DEF_IMG_DIM    = 1024;

  localparam logic [AREA_W-1:0]  MIN_AREA_RST  = 21'd1000;
  localparam logic [RATIO_W-1:0] MIN_RATIO_RST = 24'd32768;
  localparam logic [AREA_W-1:0]  AREA_MAX      = {AREA_W{1'b1}};

  localparam logic [PIX_W-1:0] OUT_SMALL = 8'd80;
  localparam logic [PIX_W-1:0] OUT_THIN  = 8'd160;

  localparam logic [1:0] MODE_CLEAR    = 2'd0;
  localparam logic [1:0] MODE_ACCUM    = 2'd1;
  localparam logic [1:0] MODE_CLASSIFY = 2'd2;

  localparam logic [1:0] VERDICT_KEEP  = 2'd0;
  localparam logic [1:0] VERDICT_THIN  = 2'd1;
  localparam logic [1:0] VERDICT_SMALL = 2'd2;

  localparam logic REG_MIN_AREA  = 1'b0;
  localparam logic REG_MIN_RATIO = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [LAB_W-1:0]   region;
    logic [PIX_W-1:0]   pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [1:0]       verdict;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ACCUM,
    OP_CLASS,
    OP_PASS
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [LAB_W-1:0]   region;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pix;
  } job_t;

  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [COORD_W-1:0] xmin;
    logic [COORD_W-1:0] xmax;
    logic [COORD_W-1:0] ymin;
    logic [COORD_W-1:0] ymax;
  } stats_t;

  localparam int STATS_W = $bits(stats_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic job_pop;
    logic ram_we;
    logic load_cls;
    logic load_prod;
    logic out_load;
  } back_ctl_t;

endpackage

FILE: rtl/core/rafc_ram.sv
// rafc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rafc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/rafc_front.sv
// rafc_front: accepts input items, sorts them into jobs and holds a two-entry job queue.
// Depends on rafc_pkg.
module rafc_front #(
  parameter int MAX_LABELS = rafc_pkg::DEF_MAX_LABELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rafc_pkg::in_item_t in_item,
  output logic              job_valid,
  output rafc_pkg::job_t    job,
  input  logic              job_pop
);

  rafc_pkg::job_t q [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     cnt;
  logic [1:0]     cnt_next;

  logic           lab_ok;
  logic           keep;
  logic           wr_en;
  rafc_pkg::job_t j;

  assign lab_ok = 32'(in_item.region) < MAX_LABELS;

  always_comb begin
    j.region = in_item.region;
    j.x      = in_item.pos_x;
    j.y      = in_item.pos_y;
    j.pix    = in_item.pixel_in;
    j.op     = rafc_pkg::OP_PASS;
    keep     = 1'b0;
    case (in_item.mode)
      rafc_pkg::MODE_CLEAR: begin
        j.op = rafc_pkg::OP_CLEAR;
        keep = lab_ok;
      end
      rafc_pkg::MODE_ACCUM: begin
        j.op = rafc_pkg::OP_ACCUM;
        keep = lab_ok && (in_item.region != '0);
      end
      rafc_pkg::MODE_CLASSIFY: begin
        // background and out-of-range labels keep the original value
        j.op = (lab_ok && (in_item.region != '0)) ? rafc_pkg::OP_CLASS : rafc_pkg::OP_PASS;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign wr_en     = push && !full && keep;
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (wr_en && !job_pop) begin
      cnt_next = cnt + 2'd1;
    end else if (!wr_en && job_pop) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= j;
    end
  end

endmodule

FILE: rtl/core/rafc_back.sv
// rafc_back: executes jobs against the label statistics RAM and produces results.
// Depends on rafc_pkg; drives an external rafc_ram instance.
module rafc_back #(
  parameter int                            DEPTH      = rafc_pkg::DEF_MAX_LABELS,
  parameter logic [rafc_pkg::COORD_W-1:0] COORD_INIT = '1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  rafc_pkg::job_t                job,
  output logic                          job_pop,
  input  logic [rafc_pkg::AREA_W-1:0]   min_area,
  input  logic [rafc_pkg::RATIO_W-1:0]  min_ratio,
  output logic                          empty,
  input  logic                          pop,
  output rafc_pkg::out_item_t           out_item,
  output logic                          ram_we,
  output logic [$clog2(DEPTH)-1:0]      ram_waddr,
  output logic [rafc_pkg::STATS_W-1:0]  ram_wdata,
  output logic [$clog2(DEPTH)-1:0]      ram_raddr,
  input  logic [rafc_pkg::STATS_W-1:0]  ram_rdata
);

  localparam int AW = $clog2(DEPTH);

  rafc_pkg::state_t  state;
  rafc_pkg::state_t  state_next;
  rafc_pkg::back_ctl_t ctl;

  rafc_pkg::job_t    cur;
  logic [DEPTH-1:0]  vld;
  logic              vld_q;
  logic              out_valid;
  rafc_pkg::out_item_t out_r;

  logic [rafc_pkg::AREA_W-1:0] area_q;
  logic [rafc_pkg::WH_W-1:0]   wh_q;
  logic [rafc_pkg::PROD_W-1:0] prod_q;

  rafc_pkg::stats_t ent;
  rafc_pkg::stats_t upd;
  logic [rafc_pkg::COORD_W-1:0] w;
  logic [rafc_pkg::COORD_W-1:0] h;
  logic [AW-1:0] job_addr;
  logic [AW-1:0] cur_addr;
  logic start;
  logic is_small;
  logic thin;

  assign job_addr  = job.region[AW-1:0];
  assign cur_addr  = cur.region[AW-1:0];
  assign start     = job_valid && !out_valid;
  assign ram_raddr = job_addr;
  assign ram_waddr = cur_addr;

  // never-written or cleared entries read as the reset statistics
  always_comb begin
    if (vld_q) begin
      ent = rafc_pkg::stats_t'(ram_rdata);
    end else begin
      ent.area = '0;
      ent.xmin = COORD_INIT;
      ent.xmax = '0;
      ent.ymin = COORD_INIT;
      ent.ymax = '0;
    end
  end

  always_comb begin
    upd      = ent;
    upd.area = (ent.area < rafc_pkg::AREA_MAX) ? ent.area + rafc_pkg::AREA_W'(1) : ent.area;
    if (cur.x < ent.xmin) upd.xmin = cur.x;
    if (cur.x > ent.xmax) upd.xmax = cur.x;
    if (cur.y < ent.ymin) upd.ymin = cur.y;
    if (cur.y > ent.ymax) upd.ymax = cur.y;
  end
  assign ram_wdata = upd;

  always_comb begin
    w = ent.xmax - ent.xmin;
    h = ent.ymax - ent.ymin;
    if (w == '0) w = rafc_pkg::COORD_W'(1);
    if (h == '0) h = rafc_pkg::COORD_W'(1);
  end

  assign is_small = area_q <= min_area;
  assign thin  = rafc_pkg::PROD_W'({area_q, {rafc_pkg::FRAC_W{1'b0}}}) <= prod_q;

  always_comb begin
    state_next = state;
    case (state)
      rafc_pkg::ST_IDLE: begin
        if (start && (job.op == rafc_pkg::OP_ACCUM || job.op == rafc_pkg::OP_CLASS)) begin
          state_next = rafc_pkg::ST_READ;
        end
      end
      rafc_pkg::ST_READ: begin
        state_next = (cur.op == rafc_pkg::OP_CLASS) ? rafc_pkg::ST_MUL : rafc_pkg::ST_IDLE;
      end
      rafc_pkg::ST_MUL: state_next = rafc_pkg::ST_CMP;
      rafc_pkg::ST_CMP: state_next = rafc_pkg::ST_IDLE;
      default: state_next = rafc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      rafc_pkg::ST_IDLE: begin
        ctl.job_pop  = start;
        ctl.out_load = start && (job.op == rafc_pkg::OP_PASS);
      end
      rafc_pkg::ST_READ: begin
        ctl.ram_we   = (cur.op == rafc_pkg::OP_ACCUM);
        ctl.load_cls = (cur.op == rafc_pkg::OP_CLASS);
      end
      rafc_pkg::ST_MUL: ctl.load_prod = 1'b1;
      rafc_pkg::ST_CMP: ctl.out_load  = 1'b1;
      default: ctl = '0;
    endcase
  end

  assign job_pop  = ctl.job_pop;
  assign ram_we   = ctl.ram_we;
  assign empty    = !out_valid;
  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rafc_pkg::ST_IDLE;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.job_pop && job.op == rafc_pkg::OP_CLEAR) begin
        vld[job_addr] <= 1'b0;
      end
      if (ctl.ram_we) begin
        vld[cur_addr] <= 1'b1;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.job_pop) begin
      cur   <= job;
      vld_q <= vld[job_addr];
    end
    if (ctl.load_cls) begin
      area_q <= ent.area;
      wh_q   <= rafc_pkg::WH_W'(w) * rafc_pkg::WH_W'(h);
    end
    if (ctl.load_prod) begin
      prod_q <= rafc_pkg::PROD_W'(min_ratio) * rafc_pkg::PROD_W'(wh_q);
    end
    if (ctl.out_load) begin
      if (state == rafc_pkg::ST_IDLE) begin
        out_r.pixel_out <= job.pix;
        out_r.verdict   <= rafc_pkg::VERDICT_KEEP;
      end else if (is_small) begin
        out_r.pixel_out <= rafc_pkg::OUT_SMALL;
        out_r.verdict   <= rafc_pkg::VERDICT_SMALL;
      end else if (thin) begin
        out_r.pixel_out <= rafc_pkg::OUT_THIN;
        out_r.verdict   <= rafc_pkg::VERDICT_THIN;
      end else begin
        out_r.pixel_out <= cur.pix;
        out_r.verdict   <= rafc_pkg::VERDICT_KEEP;
      end
    end
  end

endmodule

FILE: rtl/core/region_area_fill_classifier_top.sv
// Region area fill classifier top: APB registers, front job queue, back executor, stats RAM.
// Depends on rafc_pkg, rafc_front, rafc_back, rafc_ram.
// Classify: job pop with stats RAM read, READ, MUL (two-step multiply), CMP, output register.
// Background/out-of-range classify, clear and accumulate skip the multiply; the back end takes
//   a new job only when idle and with no result waiting in its output register.
// Reset (rst, synchronous): queues empty, label entries read as cleared, min_area=1000, 0.5.
module region_area_fill_classifier_top #(
  parameter int MAX_LABELS = rafc_pkg::DEF_MAX_LABELS,
  parameter int IMG_DIM    = rafc_pkg::DEF_IMG_DIM
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rafc_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output rafc_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // labels are 8 bits, so the table never needs more than 256 entries
  localparam int DEPTH = (MAX_LABELS < 256) ? MAX_LABELS : 256;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [rafc_pkg::COORD_W-1:0] COORD_INIT =
    rafc_pkg::COORD_W'((IMG_DIM - 1) & ((1 << rafc_pkg::COORD_W) - 1));

  logic [rafc_pkg::AREA_W-1:0]  min_area;
  logic [rafc_pkg::RATIO_W-1:0] min_ratio;
  logic                         cfg_wr;

  // Configuration: word registers, selected by paddr[2]; writes land on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area  <= rafc_pkg::MIN_AREA_RST;
      min_ratio <= rafc_pkg::MIN_RATIO_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == rafc_pkg::REG_MIN_AREA) begin
        min_area <= pwdata[rafc_pkg::AREA_W-1:0];
      end else begin
        min_ratio <= pwdata[rafc_pkg::RATIO_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rafc_pkg::REG_MIN_RATIO) begin
      prdata = 32'(min_ratio);
    end else begin
      prdata = 32'(min_area);
    end
  end

  // Front: decode and queue; back: per-label RMW and the fill-ratio test.
  logic           job_valid;
  logic           job_pop;
  rafc_pkg::job_t job;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [rafc_pkg::STATS_W-1:0] ram_wdata;
  logic [rafc_pkg::STATS_W-1:0] ram_rdata;

  rafc_front #(
    .MAX_LABELS(MAX_LABELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop)
  );

  rafc_back #(
    .DEPTH     (DEPTH),
    .COORD_INIT(COORD_INIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop),
    .min_area (min_area),
    .min_ratio(min_ratio),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  rafc_ram #(
    .WIDTH(rafc_pkg::STATS_W),
    .DEPTH(DEPTH)
  ) u_stats (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

FILE: rtl/core/rafc_checker.sv
// rafc_checker: port-level assertions for the classifier, bound to the top level.
// Depends on rafc_pkg and region_area_fill_classifier_top.
module rafc_checker (
  input logic                clk,
  input logic                rst,
  input logic                empty,
  input logic                pop,
  input rafc_pkg::out_item_t out_item
);

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

  a_small: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.verdict == rafc_pkg::VERDICT_SMALL) |->
      (out_item.pixel_out == rafc_pkg::OUT_SMALL))
    else $error("small-area verdict without 80");

  a_thin: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.verdict == rafc_pkg::VERDICT_THIN) |->
      (out_item.pixel_out == rafc_pkg::OUT_THIN))
    else $error("low-fill verdict without 160");

  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.verdict == rafc_pkg::VERDICT_KEEP ||
                out_item.verdict == rafc_pkg::VERDICT_THIN ||
                out_item.verdict == rafc_pkg::VERDICT_SMALL))
    else $error("undefined verdict code");

endmodule

bind region_area_fill_classifier_top rafc_checker u_rafc_checker (
  .clk     (clk),
  .rst     (rst),
  .empty   (empty),
  .pop     (pop),
  .out_item(out_item)
);
